// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define TFBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define TFBM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/tfbm_pkg.sv -----
`default_nettype none

package tfbm_pkg;

    // default sizes
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int ANGLE_BITS_DEF  = 20;
    localparam int ID_BITS_DEF     = 17;

    // command codes on the input tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status codes on the output tuser
    localparam logic [2:0] STS_LOADED  = 3'd0;
    localparam logic [2:0] STS_FULL    = 3'd1;
    localparam logic [2:0] STS_MATCH   = 3'd2;
    localparam logic [2:0] STS_EMPTY   = 3'd3;
    localparam logic [2:0] STS_CLEARED = 3'd4;

    // search sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- sv/triangle_feature_best_match.sv -----
// load, clear and query on an empty table: result word one cycle after accept
// query on N entries: 2*N+6 cycles from accept to result word, set by one shared
// distance unit reading one table entry per cycle, direct pass then swapped pass
// one item in flight; next item accepted once the result register is free
// synchronous active-low reset clears the entry count and control state;
// table contents are not cleared and need no clearing pass
`default_nettype none

module triangle_feature_best_match #(
    parameter int TABLE_DEPTH = tfbm_pkg::TABLE_DEPTH_DEF,
    parameter int ANGLE_BITS  = tfbm_pkg::ANGLE_BITS_DEF,
    parameter int ID_BITS     = tfbm_pkg::ID_BITS_DEF,
    localparam int IN_FIELDS_W  = 3 * ANGLE_BITS + 3 * ID_BITS,
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int DIST_W       = ANGLE_BITS + 2,
    localparam int OUT_FIELDS_W = 3 * ID_BITS + DIST_W + 1,
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // angle_beta, angle_first, angle_second, id_center, id_near, id_second
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  wire  [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // match_center, match_near, match_second, match_distance, match_swapped
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [2:0]            m_axis_tuser
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int A      = ANGLE_BITS;

    tfbm_pkg::t_state r_state;
    tfbm_pkg::t_state n_state;

    logic [CNT_W-1:0]       r_count;
    logic [ADDR_W-1:0]      r_last;
    logic [ADDR_W-1:0]      r_idx;
    logic                   r_pass;
    logic [A-1:0]           r_q_beta;
    logic [A-1:0]           r_q_first;
    logic [A-1:0]           r_q_second;

    logic [IN_FIELDS_W-1:0] r_mem [TABLE_DEPTH];
    logic [IN_FIELDS_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]      w_rd_addr;

    logic                   r_s1_vld;
    logic                   r_s1_pass;
    logic                   r_s1_first;
    logic [ADDR_W-1:0]      r_s1_idx;
    logic                   r_s2_vld;
    logic                   r_s2_pass;
    logic                   r_s2_first;
    logic [ADDR_W-1:0]      r_s2_idx;
    logic [DIST_W-1:0]      w_dist;

    logic [DIST_W-1:0]      r_best_d;
    logic [ADDR_W-1:0]      r_best_idx;
    logic                   r_best_swp;

    logic                   r_m_valid;
    logic [OUT_DATA_W-1:0]  r_m_data;
    logic [2:0]             r_m_user;

    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_issue;
    logic                   w_out_load;
    logic [OUT_DATA_W-1:0]  w_out_data;
    logic [2:0]             w_out_user;

    // input word fields
    logic [A-1:0]           w_in_beta;
    logic [A-1:0]           w_in_first;
    logic [A-1:0]           w_in_second;

    assign w_in_beta   = s_axis_tdata[A-1:0];
    assign w_in_first  = s_axis_tdata[2*A-1:A];
    assign w_in_second = s_axis_tdata[3*A-1:2*A];

    // handshake
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == tfbm_pkg::S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count >= CNT_W'(TABLE_DEPTH));

    // sequencer next state and result word
    always_comb begin
        n_state    = r_state;
        w_issue    = 1'b0;
        w_rd_addr  = r_idx;
        w_out_load = 1'b0;
        w_out_data = '0;
        w_out_user = tfbm_pkg::STS_LOADED;
        case (r_state)
            tfbm_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tuser)
                        tfbm_pkg::CMD_LOAD: begin
                            w_out_load = 1'b1;
                            w_out_user = w_full ? tfbm_pkg::STS_FULL : tfbm_pkg::STS_LOADED;
                        end
                        tfbm_pkg::CMD_QUERY: begin
                            if (r_count == '0) begin
                                w_out_load = 1'b1;
                                w_out_user = tfbm_pkg::STS_EMPTY;
                            end else begin
                                n_state = tfbm_pkg::S_SCAN;
                            end
                        end
                        tfbm_pkg::CMD_CLEAR: begin
                            w_out_load = 1'b1;
                            w_out_user = tfbm_pkg::STS_CLEARED;
                        end
                        default: ;
                    endcase
                end
            end
            tfbm_pkg::S_SCAN: begin
                w_issue   = 1'b1;
                w_rd_addr = r_idx;
                if (r_pass && (r_idx == r_last)) begin
                    n_state = tfbm_pkg::S_DRAIN;
                end
            end
            tfbm_pkg::S_DRAIN: begin
                w_rd_addr = r_best_idx;
                if (!r_s1_vld && !r_s2_vld) begin
                    n_state = tfbm_pkg::S_FETCH;
                end
            end
            tfbm_pkg::S_FETCH: begin
                w_rd_addr = r_best_idx;
                n_state   = tfbm_pkg::S_DONE;
            end
            tfbm_pkg::S_DONE: begin
                w_rd_addr = r_best_idx;
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_user = tfbm_pkg::STS_MATCH;
                    w_out_data = OUT_DATA_W'({r_best_swp, r_best_d,
                                              r_rd_data[IN_FIELDS_W-1:3*A]});
                    n_state    = tfbm_pkg::S_IDLE;
                end
            end
            default: n_state = tfbm_pkg::S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfbm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept && (s_axis_tuser == tfbm_pkg::CMD_LOAD) && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end else if (w_accept && (s_axis_tuser == tfbm_pkg::CMD_CLEAR)) begin
            r_count <= '0;
        end
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_accept && (s_axis_tuser == tfbm_pkg::CMD_LOAD) && !w_full) begin
            r_mem[r_count[ADDR_W-1:0]] <= s_axis_tdata[IN_FIELDS_W-1:0];
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // query capture and scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pass <= 1'b0;
        end else if (w_accept && (s_axis_tuser == tfbm_pkg::CMD_QUERY)) begin
            r_idx  <= '0;
            r_pass <= 1'b0;
        end else if (w_issue) begin
            if (r_idx == r_last) begin
                r_idx  <= '0;
                r_pass <= 1'b1;
            end else begin
                r_idx <= r_idx + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (s_axis_tuser == tfbm_pkg::CMD_QUERY)) begin
            r_q_beta   <= w_in_beta;
            r_q_first  <= w_in_first;
            r_q_second <= w_in_second;
            r_last     <= ADDR_W'(r_count - CNT_W'(1));
        end
    end

    // tags following each entry through read and distance stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pass  <= r_pass;
        r_s1_first <= !r_pass && (r_idx == '0);
        r_s1_idx   <= r_idx;
        r_s2_pass  <= r_s1_pass;
        r_s2_first <= r_s1_first;
        r_s2_idx   <= r_s1_idx;
    end

    // shared distance unit
    tfbm_dist #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_dist (
        .i_clk      (i_clk),
        .i_q_beta   (r_q_beta),
        .i_q_first  (r_q_first),
        .i_q_second (r_q_second),
        .i_e_beta   (r_rd_data[A-1:0]),
        .i_e_first  (r_rd_data[2*A-1:A]),
        .i_e_second (r_rd_data[3*A-1:2*A]),
        .i_swap     (r_s1_pass),
        .o_dist     (w_dist)
    );

    // running best, strict less-than keeps the first minimum
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && (r_s2_first || (w_dist < r_best_d))) begin
            r_best_d   <= w_dist;
            r_best_idx <= r_s2_idx;
            r_best_swp <= r_s2_pass;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= w_out_data;
            r_m_user <= w_out_user;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

`default_nettype wire

// ----- sv/tfbm_dist.sv -----
`default_nettype none

// shared l1 distance unit, one entry per cycle, result registered
module tfbm_dist #(
    parameter int ANGLE_BITS = tfbm_pkg::ANGLE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire  [ANGLE_BITS-1:0]  i_q_beta,
    input  wire  [ANGLE_BITS-1:0]  i_q_first,
    input  wire  [ANGLE_BITS-1:0]  i_q_second,
    input  wire  [ANGLE_BITS-1:0]  i_e_beta,
    input  wire  [ANGLE_BITS-1:0]  i_e_first,
    input  wire  [ANGLE_BITS-1:0]  i_e_second,
    input  wire                    i_swap,
    output logic [ANGLE_BITS+1:0]  o_dist
);

    logic [ANGLE_BITS-1:0] w_qa;
    logic [ANGLE_BITS-1:0] w_qb;
    logic [ANGLE_BITS-1:0] w_d0;
    logic [ANGLE_BITS-1:0] w_d1;
    logic [ANGLE_BITS-1:0] w_d2;
    logic [ANGLE_BITS+1:0] r_dist;

    // swapped pass exchanges the query side angles
    assign w_qa = i_swap ? i_q_second : i_q_first;
    assign w_qb = i_swap ? i_q_first  : i_q_second;

    // absolute differences
    assign w_d0 = (i_q_beta >= i_e_beta) ? (i_q_beta - i_e_beta) : (i_e_beta - i_q_beta);
    assign w_d1 = (w_qa >= i_e_first) ? (w_qa - i_e_first) : (i_e_first - w_qa);
    assign w_d2 = (w_qb >= i_e_second) ? (w_qb - i_e_second) : (i_e_second - w_qb);

    // sum of the three, registered
    always_ff @(posedge i_clk) begin
        r_dist <= {2'b00, w_d0} + {2'b00, w_d1} + {2'b00, w_d2};
    end

    assign o_dist = r_dist;

endmodule

`default_nettype wire

// ----- sv/tfbm_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module tfbm_checker #(
    parameter int ANGLE_BITS = tfbm_pkg::ANGLE_BITS_DEF,
    parameter int ID_BITS    = tfbm_pkg::ID_BITS_DEF,
    localparam int OUT_FIELDS_W = 3 * ID_BITS + ANGLE_BITS + 3,
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  s_axis_tvalid,
    input wire                  s_axis_tready,
    input wire [1:0]            s_axis_tuser,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [OUT_DATA_W-1:0] m_axis_tdata,
    input wire [2:0]            m_axis_tuser
);

    logic                  w_in_acc;
    logic                  w_load_acc;
    logic                  w_query_acc;
    logic                  w_load_sts;
    logic                  w_query_sts;
    logic                  w_out_stall;
    logic [OUT_DATA_W+3:0] w_word;
    logic                  w_out_other;
    logic                  w_data_zero;
    logic                  w_bad_status;

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_load_acc   = w_in_acc && (s_axis_tuser == tfbm_pkg::CMD_LOAD);
    assign w_query_acc  = w_in_acc && (s_axis_tuser == tfbm_pkg::CMD_QUERY);
    assign w_load_sts   = m_axis_tvalid && ((m_axis_tuser == tfbm_pkg::STS_LOADED) ||
                                            (m_axis_tuser == tfbm_pkg::STS_FULL));
    assign w_query_sts  = !s_axis_tready ||
                          (m_axis_tvalid && (m_axis_tuser == tfbm_pkg::STS_EMPTY));
    assign w_out_stall  = m_axis_tvalid && !m_axis_tready;
    assign w_word       = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
    assign w_out_other  = m_axis_tvalid && (m_axis_tuser != tfbm_pkg::STS_MATCH);
    assign w_data_zero  = (m_axis_tdata == '0);
    assign w_bad_status = m_axis_tvalid && (m_axis_tuser > tfbm_pkg::STS_CLEARED);

    // a stalled result word holds
    `TFBM_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> $stable(w_word), "held word changed")

    // a load answers in the next cycle with loaded or full
    `TFBM_ASSERT(a_load_resp, i_clk, i_rst_n, w_load_acc |=> w_load_sts, "load not answered")

    // a query either answers empty or closes the input while it searches
    `TFBM_ASSERT(a_query_busy, i_clk, i_rst_n, w_query_acc |=> w_query_sts, "input open in search")

    // only a match carries ids and distance
    `TFBM_ASSERT(a_zero_fields, i_clk, i_rst_n, w_out_other |-> w_data_zero, "nonzero fields")

    // status stays within its codes
    `TFBM_NEVER(a_status_range, i_clk, i_rst_n, w_bad_status, "bad status code")

endmodule

bind triangle_feature_best_match tfbm_checker #(
    .ANGLE_BITS(ANGLE_BITS),
    .ID_BITS   (ID_BITS)
) u_tfbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
